FILE: src/rsag_pkg.sv
`timescale 1ns / 1ps
package rsag_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Field widths of the input and result words.
    localparam int CMD_W  = 2;
    localparam int XY_W   = 12;
    localparam int SIZE_W = 13;
    localparam int IDX_W  = 24;
    localparam int LOG2_W = 4;

    // Internal widths. Walk positions are signed and reach roughly three
    // coordinate spans plus the largest ring count on either side of zero.
    localparam int WALK_W = 17;
    localparam int RING_W = SIZE_W;
    localparam int ODD_W  = RING_W + 1;
    localparam int REM_W  = ODD_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H_LOG2 = 2'd1;
    localparam logic [LOG2_W-1:0]    MAP_LOG2_RESET = 4'd8;

    localparam logic [CMD_W-1:0] CMD_SQUARE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RING   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd2;

    typedef enum logic [1:0] {
        ST_PROBE  = 2'd0,
        ST_FOUND  = 2'd1,
        ST_NONE   = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_START_SQ,
        OP_START_RING,
        OP_SETUP_AROUND,
        OP_STEP,
        OP_ITER,
        OP_ENC,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status emit_status;
    } t_ctl;

    typedef struct packed {
        logic active;
        logic centre_pending;
        logic centre_on_map;
        logic exhausted;
        logic iter_found;
        logic iter_jump;
        logic enclosed;
        logic out_free;
    } t_stat;

endpackage

FILE: src/rsag_ctrl.sv
`timescale 1ns / 1ps
module rsag_ctrl import rsag_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [CMD_W-1:0] i_command,
    input  logic             i_hit,
    input  t_stat            i_stat,
    output t_ctl             o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTRE,
        S_WALK,
        S_ENC,
        S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_status r_emit, n_emit;
    logic    in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state           = r_state;
        n_emit            = r_emit;
        o_ctl.op          = OP_NOP;
        o_ctl.emit_status = r_emit;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_SQUARE: begin
                            o_ctl.op = OP_START_SQ;
                            n_state  = S_CENTRE;
                        end
                        CMD_RING: begin
                            o_ctl.op = OP_START_RING;
                            n_state  = S_WALK;
                        end
                        CMD_PROBE: begin
                            if (!i_stat.active) begin
                                n_emit  = ST_REJECT;
                                n_state = S_EMIT;
                            end else if (i_hit) begin
                                n_emit  = ST_FOUND;
                                n_state = S_EMIT;
                            end else if (i_stat.centre_pending) begin
                                o_ctl.op = OP_SETUP_AROUND;
                                n_state  = S_WALK;
                            end else begin
                                o_ctl.op = OP_STEP;
                                n_state  = S_WALK;
                            end
                        end
                        default: begin
                            n_emit  = ST_REJECT;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_CENTRE: begin
                if (!i_stat.centre_pending) begin
                    n_state = S_WALK;
                end else if (i_stat.centre_on_map) begin
                    n_emit  = ST_PROBE;
                    n_state = S_EMIT;
                end else begin
                    o_ctl.op = OP_SETUP_AROUND;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                // One side segment, one turn or one half of a ring corner per cycle.
                o_ctl.op = OP_ITER;
                if (i_stat.exhausted) begin
                    n_emit  = ST_NONE;
                    n_state = S_EMIT;
                end else if (i_stat.iter_found) begin
                    n_emit  = ST_PROBE;
                    n_state = S_EMIT;
                end else if (i_stat.iter_jump) begin
                    n_state = S_ENC;
                end
            end
            S_ENC: begin
                if (i_stat.exhausted || i_stat.enclosed) begin
                    n_emit  = ST_NONE;
                    n_state = S_EMIT;
                end else begin
                    o_ctl.op = OP_ENC;
                    n_state  = S_WALK;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctl.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= ST_REJECT;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    a_reject_idle_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_command == CMD_PROBE && !i_stat.active
        |=> r_state == S_EMIT && r_emit == ST_REJECT)
        else $error("probe word without a running search was not rejected");

    a_exhausted_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && i_stat.exhausted
        |=> r_state == S_EMIT && r_emit == ST_NONE)
        else $error("used-up rings did not end the search");

    a_emit_waits_for_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && !i_stat.out_free |=> r_state == S_EMIT)
        else $error("result left the sequencer while the output register was full");

endmodule

FILE: src/rsag_dpath.sv
`timescale 1ns / 1ps
module rsag_dpath import rsag_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LOG2_W-1:0]    i_cfg_data,
    input  logic [XY_W-1:0]      i_start_x,
    input  logic [XY_W-1:0]      i_start_y,
    input  logic [SIZE_W-1:0]    i_search_size,
    input  logic [XY_W-1:0]      i_hole_width,
    input  logic [XY_W-1:0]      i_hole_height,
    input  t_ctl                 i_ctl,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [XY_W-1:0]      o_tile_x,
    output logic [XY_W-1:0]      o_tile_y,
    output logic [IDX_W-1:0]     o_tile_index
);

    localparam int LOG_W = $clog2(COORD_BITS + 1);
    localparam logic [LOG_W-1:0] LOG_CAP = LOG_W'(COORD_BITS);

    logic [LOG2_W-1:0]        r_map_w_log2, r_map_h_log2;
    logic signed [WALK_W-1:0] r_walk_x, r_walk_y;
    logic [RING_W-1:0]        r_ring, r_limit;
    logic [1:0]               r_dir;
    logic [REM_W-1:0]         r_rem;
    logic [ODD_W-1:0]         r_odd;
    logic [XY_W-1:0]          r_inner_w, r_inner_h;
    logic                     r_active, r_pending;
    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic [XY_W-1:0]          r_tile_x, r_tile_y;
    logic [IDX_W-1:0]         r_tile_index;

    function automatic logic in_range(input logic signed [WALK_W-1:0] v,
                                      input logic [LOG_W-1:0] e);
        in_range = !v[WALK_W-1] && ((v[WALK_W-2:0] >> e) == '0);
    endfunction

    function automatic logic [WALK_W-1:0] lim_minus_one(input logic [LOG_W-1:0] e);
        logic [WALK_W-1:0] one;
        one           = WALK_W'(1);
        lim_minus_one = (one << e) - one;
    endfunction

    logic [LOG_W-1:0] eff_w, eff_h, e_p, e_q;
    assign eff_w = (int'(r_map_w_log2) > COORD_BITS) ? LOG_CAP : LOG_W'(r_map_w_log2);
    assign eff_h = (int'(r_map_h_log2) > COORD_BITS) ? LOG_CAP : LOG_W'(r_map_h_log2);

    // Side walk: p runs along the side, q is fixed for the whole side.
    logic                     hor, neg, p_in, q_in, p_neg, kfail, rem_zero, on_map;
    logic signed [WALK_W-1:0] p, q, p_stop, p_run, p_step, rem_ext;
    logic [WALK_W-1:0]        lim_m1, k;
    logic [REM_W-1:0]         rem_turn, span_w, span_h;
    logic signed [WALK_W-1:0] bottom;
    logic                     enclosed;
    logic signed [WALK_W-1:0] sx_ext, sy_ext;
    logic [IDX_W-1:0]         idx_x, idx_y;

    assign hor     = !r_dir[0];
    assign neg     = (r_dir[0] == r_dir[1]);
    assign p       = hor ? r_walk_x : r_walk_y;
    assign q       = hor ? r_walk_y : r_walk_x;
    assign e_p     = hor ? eff_w : eff_h;
    assign e_q     = hor ? eff_h : eff_w;
    assign p_in    = in_range(p, e_p);
    assign q_in    = in_range(q, e_q);
    assign p_neg   = p[WALK_W-1];
    assign lim_m1  = lim_minus_one(e_p);
    assign rem_ext = $signed(WALK_W'(r_rem));

    always_comb begin
        if (neg) begin
            k = (!p_in && !p_neg) ? ($unsigned(p) - lim_m1) : '0;
        end else begin
            k = p_neg ? $unsigned(-p) : '0;
        end
    end

    assign kfail  = !q_in || (neg ? p_neg : (!p_in && !p_neg)) || (k >= WALK_W'(r_rem));
    assign p_stop = neg ? (p_in ? p : $signed(lim_m1)) : (p_neg ? '0 : p);
    assign p_run  = neg ? (p - rem_ext) : (p + rem_ext);
    assign p_step = neg ? (p - WALK_W'(1)) : (p + WALK_W'(1));

    assign rem_zero = (r_rem == '0);
    // Extent of the next side: odd directions run along the hole height.
    assign rem_turn = (r_dir[0] ? REM_W'(r_inner_w) : REM_W'(r_inner_h)) + REM_W'(r_odd);

    assign span_w   = REM_W'(r_inner_w) + REM_W'(r_odd);
    assign span_h   = REM_W'(r_inner_h) + REM_W'(r_odd);
    assign bottom   = r_walk_y + $signed(WALK_W'(span_h));
    assign enclosed = (r_walk_x < $signed(WALK_W'(span_w)))
                      && !in_range(r_walk_x, eff_w) && !r_walk_x[WALK_W-1]
                      && r_walk_y[WALK_W-1]
                      && !in_range(bottom, eff_h) && !bottom[WALK_W-1];

    assign on_map = in_range(r_walk_x, eff_w) && in_range(r_walk_y, eff_h);
    assign sx_ext = $signed(WALK_W'(i_start_x));
    assign sy_ext = $signed(WALK_W'(i_start_y));
    assign idx_x  = IDX_W'(r_walk_x[WALK_W-2:0]);
    assign idx_y  = IDX_W'(r_walk_y[WALK_W-2:0]);

    assign o_stat.active         = r_active;
    assign o_stat.centre_pending = r_pending;
    assign o_stat.centre_on_map  = on_map;
    assign o_stat.exhausted      = (r_ring >= r_limit);
    assign o_stat.iter_found     = !rem_zero && !kfail;
    assign o_stat.iter_jump      = rem_zero && (r_dir == 2'd3);
    assign o_stat.enclosed       = enclosed;
    assign o_stat.out_free       = !r_out_valid || !i_out_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_tile_x     = r_tile_x;
    assign o_tile_y     = r_tile_y;
    assign o_tile_index = r_tile_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w_log2 <= MAP_LOG2_RESET;
            r_map_h_log2 <= MAP_LOG2_RESET;
            r_walk_x     <= '0;
            r_walk_y     <= '0;
            r_ring       <= '0;
            r_limit      <= '0;
            r_dir        <= '0;
            r_rem        <= '0;
            r_odd        <= '0;
            r_inner_w    <= '0;
            r_inner_h    <= '0;
            r_active     <= 1'b0;
            r_pending    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MAP_W_LOG2) begin
                    r_map_w_log2 <= i_cfg_data;
                end else if (i_cfg_index == CFG_MAP_H_LOG2) begin
                    r_map_h_log2 <= i_cfg_data;
                end
            end

            if (i_ctl.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (i_ctl.op)
                OP_START_SQ: begin
                    r_ring    <= '0;
                    r_dir     <= '0;
                    r_odd     <= ODD_W'(1);
                    r_limit   <= RING_W'(i_search_size >> 1);
                    r_active  <= 1'b1;
                    if (i_search_size[0]) begin
                        // Odd side: the centre goes first, then rings round a 1 by 1 hole.
                        r_inner_w <= XY_W'(1);
                        r_inner_h <= XY_W'(1);
                        r_walk_x  <= sx_ext;
                        r_walk_y  <= sy_ext;
                        r_rem     <= REM_W'(2);
                        r_pending <= 1'b1;
                    end else begin
                        r_inner_w <= '0;
                        r_inner_h <= '0;
                        r_walk_x  <= sx_ext + WALK_W'(1);
                        r_walk_y  <= sy_ext;
                        r_rem     <= REM_W'(1);
                        r_pending <= 1'b0;
                    end
                end
                OP_START_RING: begin
                    r_inner_w <= i_hole_width;
                    r_inner_h <= i_hole_height;
                    r_walk_x  <= sx_ext + $signed(WALK_W'(i_hole_width)) + WALK_W'(1);
                    r_walk_y  <= sy_ext;
                    r_ring    <= '0;
                    r_dir     <= '0;
                    r_rem     <= REM_W'(i_hole_width) + REM_W'(1);
                    r_odd     <= ODD_W'(1);
                    r_limit   <= i_search_size;
                    r_pending <= 1'b0;
                    r_active  <= 1'b1;
                end
                OP_SETUP_AROUND: begin
                    r_inner_w <= XY_W'(1);
                    r_inner_h <= XY_W'(1);
                    r_walk_x  <= r_walk_x + WALK_W'(1);
                    r_walk_y  <= r_walk_y - WALK_W'(1);
                    r_ring    <= '0;
                    r_dir     <= '0;
                    r_rem     <= REM_W'(2);
                    r_odd     <= ODD_W'(1);
                    r_pending <= 1'b0;
                end
                OP_STEP: begin
                    if (hor) begin
                        r_walk_x <= p_step;
                    end else begin
                        r_walk_y <= p_step;
                    end
                    r_rem <= r_rem - REM_W'(1);
                end
                OP_ITER: begin
                    if (r_ring < r_limit) begin
                        if (rem_zero) begin
                            if (r_dir != 2'd3) begin
                                r_dir <= r_dir + 2'd1;
                                r_rem <= rem_turn;
                            end else begin
                                // Corner of the ring: step out to the next ring.
                                r_walk_x <= r_walk_x + WALK_W'(1);
                                r_walk_y <= r_walk_y - WALK_W'(1);
                                r_ring   <= r_ring + RING_W'(1);
                                r_odd    <= r_odd + ODD_W'(2);
                                r_dir    <= '0;
                            end
                        end else if (!kfail) begin
                            if (hor) begin
                                r_walk_x <= p_stop;
                            end else begin
                                r_walk_y <= p_stop;
                            end
                            r_rem <= r_rem - REM_W'(k);
                        end else begin
                            if (hor) begin
                                r_walk_x <= p_run;
                            end else begin
                                r_walk_y <= p_run;
                            end
                            r_rem <= '0;
                        end
                    end
                end
                OP_ENC: begin
                    r_rem <= span_w;
                end
                OP_EMIT: begin
                    if (i_ctl.emit_status == ST_NONE) begin
                        r_active <= 1'b0;
                    end else if (i_ctl.emit_status == ST_FOUND) begin
                        r_active  <= 1'b0;
                        r_pending <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_EMIT) begin
            r_status <= i_ctl.emit_status;
            if (i_ctl.emit_status == ST_PROBE || i_ctl.emit_status == ST_FOUND) begin
                r_tile_x     <= r_walk_x[XY_W-1:0];
                r_tile_y     <= r_walk_y[XY_W-1:0];
                r_tile_index <= (idx_y << eff_w) | idx_x;
            end else begin
                r_tile_x     <= '0;
                r_tile_y     <= '0;
                r_tile_index <= '0;
            end
        end
    end

    // A found tile may lie off a map that was resized after it was offered.
    a_offer_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == OP_EMIT && i_ctl.emit_status == ST_PROBE |-> on_map)
        else $error("tile handed out lies off the map");

    a_emit_into_free_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == OP_EMIT |-> !r_out_valid || !i_out_stall)
        else $error("result word overwrote one not yet taken");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall
        |=> r_out_valid && $stable(r_status) && $stable(r_tile_index))
        else $error("stalled result word changed");

endmodule

FILE: src/ring_scan_address_generator.sv
`timescale 1ns / 1ps
// The sequencer walks a search in steps, each covering one side segment, one turn or one
// half of a ring corner, before the result is written to the output register; a reject
// goes there without any walk step. The next input word is taken only once the result
// sits in the output register, so an output stall also holds off the next input word.
// Reset is synchronous, active low: idle.
module ring_scan_address_generator import rsag_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LOG2_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [XY_W-1:0]      i_start_x,
    input  logic [XY_W-1:0]      i_start_y,
    input  logic [SIZE_W-1:0]    i_search_size,
    input  logic [XY_W-1:0]      i_hole_width,
    input  logic [XY_W-1:0]      i_hole_height,
    input  logic                 i_hit,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [XY_W-1:0]      o_tile_x,
    output logic [XY_W-1:0]      o_tile_y,
    output logic [IDX_W-1:0]     o_tile_index
);

    t_ctl  ctl;
    t_stat stat;

    rsag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_hit      (i_hit),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    rsag_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_search_size (i_search_size),
        .i_hole_width  (i_hole_width),
        .i_hole_height (i_hole_height),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_tile_x      (o_tile_x),
        .o_tile_y      (o_tile_y),
        .o_tile_index  (o_tile_index)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rsag_pkg::*;

    localparam int COORD = COORD_BITS_DEF;
    localparam int QUIET_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [XY_W-1:0]   sx;
        logic [XY_W-1:0]   sy;
        logic [SIZE_W-1:0] size;
        logic [XY_W-1:0]   hw;
        logic [XY_W-1:0]   hh;
        logic              hit;
    } search_word_t;

    typedef struct packed {
        t_status          status;
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
        logic [IDX_W-1:0] idx;
    } tile_result_t;

    class search_scoreboard;
        logic [LOG2_W-1:0] width_log2;
        logic [LOG2_W-1:0] height_log2;
        int walk_x, walk_y, ring_idx, heading, side_left, ring_count, hole_w, hole_h;
        bit running, centre_first;
        tile_result_t tiles_due[$];
        int mismatches, checked;

        function new();
            width_log2 = MAP_LOG2_RESET;
            height_log2 = MAP_LOG2_RESET;
            walk_x = 0; walk_y = 0; ring_idx = 0; heading = 0; side_left = 0;
            ring_count = 0; hole_w = 0; hole_h = 0;
            running = 0; centre_first = 0;
            mismatches = 0; checked = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [LOG2_W-1:0] v);
            if (idx == CFG_MAP_W_LOG2) width_log2 = v;
            else if (idx == CFG_MAP_H_LOG2) height_log2 = v;
        endfunction

        function int span_log2(logic [LOG2_W-1:0] v);
            return (v > COORD) ? COORD : int'(v);
        endfunction

        function int map_w();
            return 1 << span_log2(width_log2);
        endfunction

        function int map_h();
            return 1 << span_log2(height_log2);
        endfunction

        function bit on_map(int x, int y);
            return x >= 0 && x < map_w() && y >= 0 && y < map_h();
        endfunction

        function int dir_dx(int d);
            return (d == 0) ? -1 : (d == 2) ? 1 : 0;
        endfunction

        function int dir_dy(int d);
            return (d == 1) ? 1 : (d == 3) ? -1 : 0;
        endfunction

        // Smallest number of steps along a side that lands inside [0, lim), or -1.
        function int steps_to_map(int p, int s, int lim, int r);
            int k;
            if (s < 0) begin
                k = p - lim + 1;
                if (k < 0) k = 0;
                if (k > p || k >= r) return -1;
            end else begin
                k = -p;
                if (k < 0) k = 0;
                if (k > lim - 1 - p || k >= r) return -1;
            end
            return k;
        endfunction

        function bit seek_tile();
            int dx, dy, k, left, bottom;
            while (1) begin
                if (ring_idx >= ring_count) return 0;
                if (side_left <= 0) begin
                    if (heading < 3) begin
                        heading++;
                    end else begin
                        // Corner jump to the start of the next ring out.
                        walk_x += 1;
                        walk_y -= 1;
                        ring_idx++;
                        heading = 0;
                        if (ring_idx >= ring_count) return 0;
                        left = walk_x - hole_w - 1 - 2 * ring_idx;
                        bottom = walk_y + hole_h + 1 + 2 * ring_idx;
                        if (left < 0 && walk_x >= map_w() && walk_y < 0 && bottom >= map_h())
                            return 0;
                    end
                    side_left = ((heading % 2) ? hole_h : hole_w) + 2 * ring_idx + 1;
                    continue;
                end
                dx = dir_dx(heading);
                dy = dir_dy(heading);
                if (dy == 0)
                    k = (walk_y >= 0 && walk_y < map_h())
                        ? steps_to_map(walk_x, dx, map_w(), side_left) : -1;
                else
                    k = (walk_x >= 0 && walk_x < map_w())
                        ? steps_to_map(walk_y, dy, map_h(), side_left) : -1;
                if (k >= 0) begin
                    walk_x += k * dx;
                    walk_y += k * dy;
                    side_left -= k;
                    return 1;
                end
                walk_x += side_left * dx;
                walk_y += side_left * dy;
                side_left = 0;
            end
            return 0;
        endfunction

        function void arm_rings(int sx, int sy, int radius, int w, int h);
            hole_w = w;
            hole_h = h;
            walk_x = sx + w + 1;
            walk_y = sy;
            ring_idx = 0;
            heading = 0;
            side_left = w + 1;
            ring_count = radius;
            centre_first = 0;
            running = 1;
        endfunction

        function void push_result(t_status s, bit with_tile);
            logic [63:0] xv, yv, iv;
            tile_result_t r;
            xv = '0;
            yv = '0;
            iv = '0;
            if (with_tile) begin
                xv = {32'd0, walk_x};
                yv = {32'd0, walk_y};
                iv = (yv << span_log2(width_log2)) | xv;
            end
            r.status = s;
            r.x = xv[XY_W-1:0];
            r.y = yv[XY_W-1:0];
            r.idx = iv[IDX_W-1:0];
            tiles_due.push_back(r);
        endfunction

        function void offer_next();
            if (seek_tile()) begin
                push_result(ST_PROBE, 1);
            end else begin
                running = 0;
                push_result(ST_NONE, 0);
            end
        endfunction

        function void predict_tile(search_word_t w);
            int sx, sy, size;
            sx = int'(w.sx);
            sy = int'(w.sy);
            size = int'(w.size);
            case (w.cmd)
                CMD_SQUARE: begin
                    if (size % 2) begin
                        // Odd side: the centre goes first when it lies on the map.
                        arm_rings(sx - 1, sy - 1, size / 2, 1, 1);
                        walk_x = sx;
                        walk_y = sy;
                        centre_first = 1;
                        if (on_map(sx, sy)) begin
                            push_result(ST_PROBE, 1);
                            return;
                        end
                        arm_rings(sx - 1, sy - 1, size / 2, 1, 1);
                    end else begin
                        arm_rings(sx, sy, size / 2, 0, 0);
                    end
                    offer_next();
                    return;
                end
                CMD_RING: begin
                    arm_rings(sx, sy, size, int'(w.hw), int'(w.hh));
                    offer_next();
                    return;
                end
                CMD_PROBE: begin
                    if (running) begin
                        if (w.hit) begin
                            running = 0;
                            centre_first = 0;
                            push_result(ST_FOUND, 1);
                            return;
                        end
                        if (centre_first) begin
                            arm_rings(walk_x - 1, walk_y - 1, ring_count, 1, 1);
                        end else begin
                            walk_x += dir_dx(heading);
                            walk_y += dir_dy(heading);
                            side_left -= 1;
                        end
                        offer_next();
                        return;
                    end
                end
                default: ;
            endcase
            push_result(ST_REJECT, 0);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_tile(logic [1:0] st, logic [XY_W-1:0] x, logic [XY_W-1:0] y,
                                 logic [IDX_W-1:0] idx);
            tile_result_t e;
            if (tiles_due.size() == 0) begin
                $display("%0t: unexpected word status %0d tile (%0d,%0d)", $time, st, x, y);
                mismatches++;
                return;
            end
            e = tiles_due.pop_front();
            checked++;
            field_check("status", 32'(e.status), 32'(st));
            field_check("tile_x", 32'(e.x), 32'(x));
            field_check("tile_y", 32'(e.y), 32'(y));
            field_check("tile_index", 32'(e.idx), 32'(idx));
        endfunction

        function int pending();
            return tiles_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LOG2_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_command;
    logic [XY_W-1:0]      i_start_x;
    logic [XY_W-1:0]      i_start_y;
    logic [SIZE_W-1:0]    i_search_size;
    logic [XY_W-1:0]      i_hole_width;
    logic [XY_W-1:0]      i_hole_height;
    logic                 i_hit;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [XY_W-1:0]      o_tile_x;
    logic [XY_W-1:0]      o_tile_y;
    logic [IDX_W-1:0]     o_tile_index;

    search_scoreboard sb = new();

    int send_idle = 24;
    int stall_pct = 72;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int words_sent = 0;
    int seg_w[8] = '{12, 6, 0, 15, 7, 12, 6, 3};
    int seg_h[8] = '{6, 12, 15, 0, 9, 12, 6, 1};

    ring_scan_address_generator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_search_size(i_search_size),
        .i_hole_width (i_hole_width),
        .i_hole_height(i_hole_height),
        .i_hit        (i_hit),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_tile_x     (o_tile_x),
        .o_tile_y     (o_tile_y),
        .o_tile_index (o_tile_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.predict_tile({i_command, i_start_x, i_start_y, i_search_size,
                             i_hole_width, i_hole_height, i_hit});
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_tile(o_status, o_tile_x, o_tile_y, o_tile_index);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.set_register(i_cfg_index, i_cfg_data);
    end

    // Receiver side: random stalls, plus a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic search_word_t make_word(logic [CMD_W-1:0] cmd, int sx, int sy,
                                               int size, int hw, int hh, logic hit);
        search_word_t w;
        w.cmd = cmd;
        w.sx = XY_W'(sx);
        w.sy = XY_W'(sy);
        w.size = SIZE_W'(size);
        w.hw = XY_W'(hw);
        w.hh = XY_W'(hh);
        w.hit = hit;
        return w;
    endfunction

    function automatic int pick_coord(int span);
        if ($urandom_range(7) == 0) return $urandom_range(4095);
        return $urandom_range((span + 2 > 4095) ? 4095 : span + 2);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 1) return $urandom_range(8191, 4096);
        if (r < 6) return $urandom_range(200, 13);
        return $urandom_range(12);
    endfunction

    function automatic int pick_hole();
        if ($urandom_range(7) == 0) return $urandom_range(4095);
        return $urandom_range(5);
    endfunction

    task automatic send_word(input search_word_t w);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= w.cmd;
        i_start_x     <= w.sx;
        i_start_y     <= w.sy;
        i_search_size <= w.size;
        i_hole_width  <= w.hw;
        i_hole_height <= w.hh;
        i_hit         <= w.hit;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_map_size(input logic [LOG2_W-1:0] w, input logic [LOG2_W-1:0] h);
        int r;
        for (r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (r == 0) ? CFG_MAP_W_LOG2 : CFG_MAP_H_LOG2;
            i_cfg_data  <= (r == 0) ? w : h;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly a start word followed by a run of misses that may end in a hit,
    // with some arbitrary words mixed in.
    task automatic run_random(input int n, input bit squeeze);
        int sent, k, probes;
        bit squeezed;
        sent = 0;
        squeezed = 0;
        while (sent < n) begin
            if (squeeze && !squeezed && sent >= n / 2) begin
                hold_asked++;
                squeezed = 1;
            end
            if ($urandom_range(99) < 12) begin
                send_word(make_word(CMD_W'($urandom_range(3)), $urandom, $urandom,
                                    ($urandom_range(31) == 0) ? $urandom : $urandom_range(15),
                                    $urandom, $urandom, 1'($urandom)));
                sent++;
            end else begin
                send_word(make_word($urandom_range(1) ? CMD_RING : CMD_SQUARE,
                                    pick_coord(sb.map_w()), pick_coord(sb.map_h()),
                                    pick_size(), pick_hole(), pick_hole(), 1'($urandom)));
                sent++;
                probes = $urandom_range(14, 1);
                for (k = 0; k < probes && sent < n; k++) begin
                    send_word(make_word(CMD_PROBE, $urandom, $urandom, $urandom, $urandom,
                                        $urandom,
                                        (k == probes - 1) && ($urandom_range(99) < 35)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int seg;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_MAP_W_LOG2;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_SQUARE;
        i_start_x     <= '0;
        i_start_y     <= '0;
        i_search_size <= '0;
        i_hole_width  <= '0;
        i_hole_height <= '0;
        i_hit         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words on the reset map size.
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(CMD_UNUSED, 4095, 4095, 8191, 4095, 4095, 1));
        send_word(make_word(CMD_SQUARE, 17, 3, 0, 0, 0, 0));
        send_word(make_word(CMD_SQUARE, 10, 10, 1, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_SQUARE, 0, 0, 3, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(CMD_SQUARE, 300, 5, 3, 0, 0, 0));
        send_word(make_word(CMD_SQUARE, 255, 255, 4, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_RING, 5, 5, 2, 3, 2, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(CMD_RING, 40, 40, 0, 1, 1, 0));
        send_word(make_word(CMD_RING, 4095, 4095, 8191, 4095, 4095, 0));
        send_word(make_word(CMD_SQUARE, 0, 0, 8191, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        // A new start drops the search that is still running.
        send_word(make_word(CMD_SQUARE, 128, 128, 2, 0, 0, 0));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(CMD_PROBE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_RING, 4095, 0, 4096, 0, 0, 0));

        for (seg = 0; seg < 8; seg++) begin
            settle();
            write_map_size(LOG2_W'(seg_w[seg]), LOG2_W'(seg_h[seg]));
            if (seg < 3) begin
                send_idle = 24;
                stall_pct = 72;
            end else if (seg < 6) begin
                send_idle = 72;
                stall_pct = 24;
            end else begin
                send_idle = 0;
                stall_pct = 0;
            end
            run_random(103, seg == 1 || seg == 6);
        end
        settle();

        $display("tb: %0d words sent over nine map shapes, %0d results compared, %0d mismatches",
                 words_sent, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
